// File: rtl/gsvp_pkg.sv
// ----------------------------------------------------------------------------
// gsvp_pkg
// Shared types, constants and helpers of the greedy search visit planner:
// control word layout, sequencer steps, jump conditions and status flags.
// ----------------------------------------------------------------------------
package gsvp_pkg;

  localparam int DEF_MAX_ROWS   = 16;
  localparam int DEF_MAX_COLS   = 16;
  localparam int DEF_MAX_BUDGET = 64;

  localparam int PROB_W    = 17;
  localparam int GAIN_W    = 32;
  localparam int BELIEF_W  = 16;
  localparam int COUNT_W   = 8;
  localparam int BUDGET_W  = 7;
  localparam int CELL_W    = 4;
  localparam int DIM_W     = 5;
  localparam int CMP_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = GAIN_W + PROB_W;

  localparam logic [PROB_W-1:0] ONE_Q16         = 17'h10000;
  localparam logic [PROB_W-1:0] DETECT_PROB_RST = 17'h08000;
  localparam logic [DIM_W-1:0]  GRID_DIM_RST    = 5'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_PROB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd2;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_DISPATCH,
    STEP_LOAD_INIT,
    STEP_LOAD_DECAY,
    STEP_LOAD_WRITE,
    STEP_PLAN_INIT,
    STEP_SCAN_START,
    STEP_SCAN,
    STEP_DRAIN,
    STEP_CHECK,
    STEP_TAKE,
    STEP_WRITEBACK,
    STEP_LOOP,
    STEP_FINISH
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_START,
    COND_PLAN_MODE,
    COND_CNT_ZERO,
    COND_BUDGET_ZERO,
    COND_SCAN_LAST,
    COND_NOT_FOUND,
    COND_REM_ZERO
  } cond_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LOAD,
    MUL_DECAY_GAIN,
    MUL_DECAY_BEST
  } mul_op_t;

  // one microcode word
  typedef struct packed {
    cond_t   cond;
    logic    hold;
    step_t   target;
    logic    busy;
    mul_op_t mul_op;
    logic    load_write;
    logic    plan_init;
    logic    scan_start;
    logic    scan_issue;
    logic    take;
    logic    write_back;
    logic    finish;
  } ctrl_t;

  // datapath flags tested by jumps
  typedef struct packed {
    logic plan_mode;
    logic cnt_zero;
    logic budget_zero;
    logic scan_last;
    logic not_found;
    logic rem_zero;
  } status_t;

  // zero acts as one, anything above the limit saturates to it
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/gsvp_sequencer.sv
// ----------------------------------------------------------------------------
// gsvp_sequencer
// Step counter and control store. Each step issues one control word to the
// datapath and either advances, holds or jumps on a tested condition.
// ----------------------------------------------------------------------------
module gsvp_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gsvp_pkg::status_t status,
  output gsvp_pkg::ctrl_t   ctrl
);
  import gsvp_pkg::*;

  step_t step;
  step_t step_next;
  logic  cond_hit;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_ALWAYS;
    w.target = STEP_IDLE;
    w.busy   = 1'b1;
    w.mul_op = MUL_NONE;
    unique case (s)
      STEP_IDLE: begin
        w.busy   = 1'b0;
        w.cond   = COND_NO_START;
        w.target = STEP_IDLE;
      end
      STEP_DISPATCH: begin
        w.cond   = COND_PLAN_MODE;
        w.target = STEP_PLAN_INIT;
      end
      STEP_LOAD_INIT: begin
        w.mul_op = MUL_LOAD;
        w.target = STEP_LOAD_DECAY;
      end
      STEP_LOAD_DECAY: begin
        w.mul_op = MUL_DECAY_GAIN;
        w.cond   = COND_CNT_ZERO;
        w.target = STEP_LOAD_WRITE;
        w.hold   = 1'b1;
      end
      STEP_LOAD_WRITE: begin
        w.load_write = 1'b1;
        w.target     = STEP_IDLE;
      end
      STEP_PLAN_INIT: begin
        w.plan_init = 1'b1;
        w.cond      = COND_BUDGET_ZERO;
        w.target    = STEP_FINISH;
      end
      STEP_SCAN_START: begin
        w.scan_start = 1'b1;
        w.target     = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.scan_issue = 1'b1;
        w.cond       = COND_SCAN_LAST;
        w.target     = STEP_DRAIN;
        w.hold       = 1'b1;
      end
      STEP_DRAIN: begin
        w.target = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.cond   = COND_NOT_FOUND;
        w.target = STEP_FINISH;
      end
      STEP_TAKE: begin
        w.take   = 1'b1;
        w.mul_op = MUL_DECAY_BEST;
        w.target = STEP_WRITEBACK;
      end
      STEP_WRITEBACK: begin
        w.write_back = 1'b1;
        w.cond       = COND_REM_ZERO;
        w.target     = STEP_FINISH;
      end
      STEP_LOOP: begin
        w.target = STEP_SCAN_START;
      end
      STEP_FINISH: begin
        w.finish = 1'b1;
        w.target = STEP_IDLE;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  assign ctrl = ucode(step);

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:      cond_hit = 1'b1;
      COND_NO_START:    cond_hit = !start;
      COND_PLAN_MODE:   cond_hit = status.plan_mode;
      COND_CNT_ZERO:    cond_hit = status.cnt_zero;
      COND_BUDGET_ZERO: cond_hit = status.budget_zero;
      COND_SCAN_LAST:   cond_hit = status.scan_last;
      COND_NOT_FOUND:   cond_hit = status.not_found;
      COND_REM_ZERO:    cond_hit = status.rem_zero;
      default:          cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    priority if (cond_hit) begin
      step_next = ctrl.target;
    end else if (ctrl.hold) begin
      step_next = step;
    end else begin
      step_next = step_t'(4'(step) + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: rtl/gsvp_datapath.sv
// ----------------------------------------------------------------------------
// gsvp_datapath
// Gain store and working copy, shared gain multiplier, grid scan with a
// registered maximum compare, pending-result holding and result registers.
// ----------------------------------------------------------------------------
module gsvp_datapath #(
  parameter int MAX_ROWS   = gsvp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = gsvp_pkg::DEF_MAX_COLS,
  parameter int MAX_BUDGET = gsvp_pkg::DEF_MAX_BUDGET
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  gsvp_pkg::ctrl_t                 ctrl,
  input  logic                            mode,
  input  logic [gsvp_pkg::CELL_W-1:0]     cell_row,
  input  logic [gsvp_pkg::CELL_W-1:0]     cell_col,
  input  logic [gsvp_pkg::BELIEF_W-1:0]   belief,
  input  logic [gsvp_pkg::COUNT_W-1:0]    visit_count,
  input  logic [gsvp_pkg::BUDGET_W-1:0]   budget,
  input  logic [gsvp_pkg::PROB_W-1:0]     detect_prob,
  input  logic [gsvp_pkg::DIM_W-1:0]      grid_rows,
  input  logic [gsvp_pkg::DIM_W-1:0]      grid_cols,
  output gsvp_pkg::status_t               status,
  output logic                            result_valid,
  output logic [gsvp_pkg::CELL_W-1:0]     plan_row,
  output logic [gsvp_pkg::CELL_W-1:0]     plan_col,
  output logic                            plan_empty,
  output logic                            last
);
  import gsvp_pkg::*;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // request fields held for the whole item; the visit count counts down
  logic                mode_q;
  logic [CELL_W-1:0]   row_q;
  logic [CELL_W-1:0]   col_q;
  logic [BELIEF_W-1:0] bel_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [BUDGET_W-1:0] budget_q;

  logic [PROB_W-1:0]   p_sat;
  logic [PROB_W-1:0]   eps;
  logic [DIM_W-1:0]    rows_eff;
  logic [DIM_W-1:0]    cols_eff;
  logic [BUDGET_W-1:0] budget_sat;

  logic [GAIN_W-1:0]   gain;
  logic [GAIN_W-1:0]   mul_a;
  logic [PROB_W-1:0]   mul_b;
  logic [MUL_W-1:0]    mul_p;

  logic                in_range;
  logic [ADDR_W-1:0]   load_addr;

  logic [ROW_W-1:0]    scan_row;
  logic [COL_W-1:0]    scan_col;
  logic [ADDR_W-1:0]   scan_addr;
  logic                col_last;
  logic                row_last;

  logic                rd_valid;
  logic [ROW_W-1:0]    rd_row;
  logic [COL_W-1:0]    rd_col;
  logic [ADDR_W-1:0]   rd_addr;
  logic [GAIN_W-1:0]   rd_gain;

  logic [GAIN_W-1:0]   store_mem [DEPTH];
  logic [GAIN_W-1:0]   work_mem  [DEPTH];
  logic [GAIN_W-1:0]   store_q;
  logic [GAIN_W-1:0]   work_q;
  logic                store_we;
  logic                work_we;
  logic [ADDR_W-1:0]   work_waddr;
  logic [GAIN_W-1:0]   work_wdata;

  logic [GAIN_W-1:0]   best;
  logic [ROW_W-1:0]    best_row;
  logic [COL_W-1:0]    best_col;
  logic [ADDR_W-1:0]   best_addr;
  logic                found;

  logic [BUDGET_W-1:0] rem;
  logic                first_pass;
  logic                pend_valid;
  logic [ROW_W-1:0]    pend_row;
  logic [COL_W-1:0]    pend_col;
  logic                emit;

  assign p_sat      = (detect_prob > ONE_Q16) ? ONE_Q16 : detect_prob;
  assign eps        = ONE_Q16 - p_sat;
  assign rows_eff   = dim_clamp(grid_rows, MAX_ROWS);
  assign cols_eff   = dim_clamp(grid_cols, MAX_COLS);
  assign budget_sat = (budget_q > BUDGET_W'(MAX_BUDGET)) ? BUDGET_W'(MAX_BUDGET) : budget_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      row_q    <= cell_row;
      col_q    <= cell_col;
      bel_q    <= belief;
      budget_q <= budget;
    end
  end

  // shared multiplier: belief times p on load, gain or best gain times eps on decay
  always_comb begin
    unique case (ctrl.mul_op)
      MUL_LOAD: begin
        mul_a = GAIN_W'(bel_q);
        mul_b = p_sat;
      end
      MUL_DECAY_BEST: begin
        mul_a = best;
        mul_b = eps;
      end
      default: begin
        mul_a = gain;
        mul_b = eps;
      end
    endcase
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_q <= visit_count;
    end else if (ctrl.mul_op == MUL_DECAY_GAIN && cnt_q != '0) begin
      cnt_q <= cnt_q - COUNT_W'(1);
    end
    unique case (ctrl.mul_op)
      MUL_LOAD:       gain <= mul_p[GAIN_W-1:0];
      MUL_DECAY_GAIN: begin
        if (cnt_q != '0) begin
          gain <= mul_p[GAIN_W+15:16];
        end
      end
      MUL_DECAY_BEST: gain <= mul_p[GAIN_W+15:16];
      default: ;
    endcase
  end

  // load addressing; cells outside the grid limits are dropped
  assign in_range  = (CMP_W'(row_q) < CMP_W'(MAX_ROWS)) && (CMP_W'(col_q) < CMP_W'(MAX_COLS));
  assign load_addr = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);
  assign store_we  = ctrl.load_write && in_range;

  // row-major scan
  assign scan_addr = ADDR_W'(scan_row) * ADDR_W'(MAX_COLS) + ADDR_W'(scan_col);
  assign col_last  = CMP_W'(scan_col) == CMP_W'(cols_eff - DIM_W'(1));
  assign row_last  = CMP_W'(scan_row) == CMP_W'(rows_eff - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[load_addr] <= gain;
    end
    store_q <= store_mem[scan_addr];
  end

  // the first scan of a plan copies the store into the working copy; write-back stores the chosen cell's decayed gain
  always_comb begin
    work_we    = 1'b0;
    work_waddr = rd_addr;
    work_wdata = store_q;
    priority if (ctrl.write_back) begin
      work_we    = 1'b1;
      work_waddr = best_addr;
      work_wdata = gain;
    end else if (rd_valid && first_pass) begin
      work_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_q <= work_mem[scan_addr];
  end

  assign rd_gain = first_pass ? store_q : work_q;

  always_ff @(posedge clk) begin
    if (ctrl.scan_start) begin
      scan_row <= '0;
      scan_col <= '0;
    end else if (ctrl.scan_issue) begin
      if (col_last) begin
        scan_col <= '0;
        scan_row <= scan_row + ROW_W'(1);
      end else begin
        scan_col <= scan_col + COL_W'(1);
      end
    end
    rd_row  <= scan_row;
    rd_col  <= scan_col;
    rd_addr <= scan_addr;
    if (ctrl.scan_start) begin
      best <= '0;
    end else if (rd_valid && rd_gain > best) begin
      best      <= rd_gain;
      best_row  <= rd_row;
      best_col  <= rd_col;
      best_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      first_pass <= 1'b0;
      rem        <= '0;
    end else begin
      rd_valid <= ctrl.scan_issue;
      if (ctrl.scan_start) begin
        found <= 1'b0;
      end else if (rd_valid && rd_gain > best) begin
        found <= 1'b1;
      end
      if (ctrl.plan_init) begin
        pend_valid <= 1'b0;
        first_pass <= 1'b1;
        rem        <= budget_sat;
      end else if (ctrl.take) begin
        pend_valid <= 1'b1;
        first_pass <= 1'b0;
        rem        <= rem - BUDGET_W'(1);
      end
    end
  end

  // a chosen cell waits until the next scan shows whether it is the final one
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      pend_row <= best_row;
      pend_col <= best_col;
    end
  end

  assign emit = (ctrl.take && pend_valid) || ctrl.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      plan_row   <= CELL_W'(pend_row);
      plan_col   <= CELL_W'(pend_col);
      plan_empty <= 1'b0;
      last       <= 1'b0;
    end else if (ctrl.finish) begin
      if (pend_valid) begin
        plan_row   <= CELL_W'(pend_row);
        plan_col   <= CELL_W'(pend_col);
        plan_empty <= 1'b0;
      end else begin
        plan_row   <= '0;
        plan_col   <= '0;
        plan_empty <= 1'b1;
      end
      last <= 1'b1;
    end
  end

  assign status.plan_mode   = mode_q;
  assign status.cnt_zero    = (cnt_q == '0);
  assign status.budget_zero = (budget_q == '0);
  assign status.scan_last   = row_last && col_last;
  assign status.not_found   = !found;
  assign status.rem_zero    = (rem == '0);

endmodule

// File: rtl/greedy_search_visit_planner.sv
// ----------------------------------------------------------------------------
// greedy_search_visit_planner
// Greedy visit planner: stores per-cell detection gains and emits a plan of
// cells, each the first largest positive gain in row-major order.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and busy stays high
// until every result of that request has been sent. A load request (mode 0)
// returns nothing and keeps busy high through one shared multiplier pass per
// visit. A plan request (mode 1) stops on its budget or stops early when no
// positive gain is left (no visit at all is the empty plan); a zero budget
// gives the empty plan without a scan. Each visit costs one pass of the scan
// address over the active grid of rows * cols cells. Results come out on
// result_valid for exactly one cycle each, never two in a row, and cannot be
// stalled; the final one carries last, and an empty plan gives a single
// result with plan_empty and last set. Configuration writes are always ready
// and should only be issued while busy is low.
module greedy_search_visit_planner #(
  parameter int MAX_ROWS   = gsvp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = gsvp_pkg::DEF_MAX_COLS,
  parameter int MAX_BUDGET = gsvp_pkg::DEF_MAX_BUDGET
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode,
  input  logic [gsvp_pkg::CELL_W-1:0]     cell_row,
  input  logic [gsvp_pkg::CELL_W-1:0]     cell_col,
  input  logic [gsvp_pkg::BELIEF_W-1:0]   belief,
  input  logic [gsvp_pkg::COUNT_W-1:0]    visit_count,
  input  logic [gsvp_pkg::BUDGET_W-1:0]   budget,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsvp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsvp_pkg::PROB_W-1:0]     cfg_data,
  output logic                            result_valid,
  output logic [gsvp_pkg::CELL_W-1:0]     plan_row,
  output logic [gsvp_pkg::CELL_W-1:0]     plan_col,
  output logic                            plan_empty,
  output logic                            last
);
  import gsvp_pkg::*;

  ctrl_t              ctrl;
  status_t            status;
  logic               accept;
  logic [PROB_W-1:0]  detect_prob;
  logic [DIM_W-1:0]   grid_rows;
  logic [DIM_W-1:0]   grid_cols;

  // take a request only while the sequencer sits in its idle step
  assign busy      = ctrl.busy;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_prob <= DETECT_PROB_RST;
      grid_rows   <= GRID_DIM_RST;
      grid_cols   <= GRID_DIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DETECT_PROB: detect_prob <= cfg_data;
        CFG_GRID_ROWS:   grid_rows   <= cfg_data[DIM_W-1:0];
        CFG_GRID_COLS:   grid_cols   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  gsvp_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl)
  );

  gsvp_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_BUDGET (MAX_BUDGET)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .ctrl         (ctrl),
    .mode         (mode),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .belief       (belief),
    .visit_count  (visit_count),
    .budget       (budget),
    .detect_prob  (detect_prob),
    .grid_rows    (grid_rows),
    .grid_cols    (grid_cols),
    .status       (status),
    .result_valid (result_valid),
    .plan_row     (plan_row),
    .plan_col     (plan_col),
    .plan_empty   (plan_empty),
    .last         (last)
  );

  // the final result of a plan lands as the sequencer returns to idle
  a_last_ends_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (busy == !last))
    else $error("final result and busy out of step");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && plan_empty) |-> (last && plan_row == '0 && plan_col == '0))
    else $error("empty plan result malformed");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_result_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on back-to-back cycles");

endmodule

// File: verif/tb_greedy_search_visit_planner.sv
// ----------------------------------------------------------------------------
// tb_greedy_search_visit_planner
// Self-checking bench for the greedy visit planner. Loads cell gains, asks for
// plans under several detection probabilities and grid sizes, and compares
// every emitted visit against a cycle-free model of the greedy choice.
// ----------------------------------------------------------------------------
module tb_greedy_search_visit_planner;
  timeunit 1ns;
  timeprecision 1ps;

  import gsvp_pkg::*;

  localparam int N_CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;
  // index past the last register; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // longest load: setup plus one multiplier pass per past visit, with margin
  localparam int LOAD_SETTLE = 4 + 255 + 8;

  // one planned visit as it should appear on the result ports
  typedef struct packed {
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
    logic              is_empty;
    logic              is_last;
  } visit_t;

  // Predicts plans from its own copy of the gain table and the registers,
  // and holds the visits still owed by the block.
  class visit_plan_scoreboard;
    logic [GAIN_W-1:0] cell_gain [N_CELLS];
    logic [PROB_W-1:0] detect_prob;
    logic [DIM_W-1:0]  grid_rows;
    logic [DIM_W-1:0]  grid_cols;
    visit_t            planned_visits[$];
    int                visits_seen;
    int                mismatches;

    function new();
      foreach (cell_gain[i]) cell_gain[i] = '0;
      detect_prob = DETECT_PROB_RST;
      grid_rows   = GRID_DIM_RST;
      grid_cols   = GRID_DIM_RST;
      visits_seen = 0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PROB_W-1:0] data);
      case (idx)
        CFG_DETECT_PROB: detect_prob = data;
        CFG_GRID_ROWS:   grid_rows = data[DIM_W-1:0];
        CFG_GRID_COLS:   grid_cols = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int active_dim(logic [DIM_W-1:0] v, int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
    endfunction

    function int active_rows();
      return active_dim(grid_rows, DEF_MAX_ROWS);
    endfunction

    function int active_cols();
      return active_dim(grid_cols, DEF_MAX_COLS);
    endfunction

    function logic [PROB_W-1:0] hit_prob();
      return (detect_prob > ONE_Q16) ? ONE_Q16 : detect_prob;
    endfunction

    // one miss: scale by (1 - p), truncated
    function logic [GAIN_W-1:0] miss_scale(logic [GAIN_W-1:0] g);
      logic [PROB_W-1:0] miss;
      logic [63:0]       m;
      miss = ONE_Q16 - hit_prob();
      m = 64'(g) * 64'(miss);
      return m[47:16];
    endfunction

    function void accept_request(logic m, logic [CELL_W-1:0] r, logic [CELL_W-1:0] c,
                                 logic [BELIEF_W-1:0] bel, logic [COUNT_W-1:0] cnt,
                                 logic [BUDGET_W-1:0] bud);
      logic [63:0]       prod;
      logic [GAIN_W-1:0] g;
      logic [GAIN_W-1:0] best;
      logic [GAIN_W-1:0] work [N_CELLS];
      int                steps, rows, cols, br, bc, emitted;
      bit                found;
      visit_t            v;
      if (!m) begin
        prod = 64'(bel) * 64'(hit_prob());
        g = prod[GAIN_W-1:0];
        for (int k = 0; k < int'(cnt); k++) g = miss_scale(g);
        cell_gain[int'(r) * DEF_MAX_COLS + int'(c)] = g;
        return;
      end
      steps = (int'(bud) > DEF_MAX_BUDGET) ? DEF_MAX_BUDGET : int'(bud);
      rows = active_rows();
      cols = active_cols();
      emitted = 0;
      // decay a working copy so the stored table survives the plan
      work = cell_gain;
      for (int t = 0; t < steps; t++) begin
        best = '0;
        found = 0;
        br = 0;
        bc = 0;
        for (int y = 0; y < rows; y++) begin
          for (int x = 0; x < cols; x++) begin
            if (work[y * DEF_MAX_COLS + x] > best) begin
              best = work[y * DEF_MAX_COLS + x];
              br = y;
              bc = x;
              found = 1;
            end
          end
        end
        if (!found) break;
        v.row = CELL_W'(br);
        v.col = CELL_W'(bc);
        v.is_empty = 1'b0;
        v.is_last = 1'b0;
        planned_visits = {planned_visits, v};
        emitted++;
        work[br * DEF_MAX_COLS + bc] = miss_scale(best);
      end
      if (emitted == 0) begin
        v.row = '0;
        v.col = '0;
        v.is_empty = 1'b1;
        v.is_last = 1'b1;
        planned_visits = {planned_visits, v};
      end else begin
        planned_visits[planned_visits.size() - 1].is_last = 1'b1;
      end
    endfunction

    function void check_visit(logic [CELL_W-1:0] row, logic [CELL_W-1:0] col,
                              logic empty_f, logic last_f);
      visit_t want;
      visits_seen++;
      if (planned_visits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result with no plan pending: row %0d col %0d empty %b last %b",
                   $realtime, row, col, empty_f, last_f);
        return;
      end
      want = planned_visits.pop_front();
      if (want.row !== row || want.col !== col || want.is_empty !== empty_f ||
          want.is_last !== last_f) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: visit %0d differs: ", $realtime, visits_seen,
                   "expected row %0d col %0d empty %b last %b, ",
                   want.row, want.col, want.is_empty, want.is_last,
                   "got row %0d col %0d empty %b last %b",
                   row, col, empty_f, last_f);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 mode;
  logic [CELL_W-1:0]    cell_row;
  logic [CELL_W-1:0]    cell_col;
  logic [BELIEF_W-1:0]  belief;
  logic [COUNT_W-1:0]   visit_count;
  logic [BUDGET_W-1:0]  budget;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PROB_W-1:0]    cfg_data;
  logic                 result_valid;
  logic [CELL_W-1:0]    plan_row;
  logic [CELL_W-1:0]    plan_col;
  logic                 plan_empty;
  logic                 last;

  visit_plan_scoreboard sb;
  bit cell_loaded [N_CELLS];
  bit steady;
  int n_loads, n_plans, n_writes;

  greedy_search_visit_planner dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .cell_row(cell_row),
    .cell_col(cell_col),
    .belief(belief),
    .visit_count(visit_count),
    .budget(budget),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .plan_row(plan_row),
    .plan_col(plan_col),
    .plan_empty(plan_empty),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous ceiling: far above the slowest correct run of this stimulus.
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Results cannot be held off, so take every strobe at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) sb.check_visit(plan_row, plan_col, plan_empty, last);
  end

  // Drop start for a random stretch, mostly short, now and then long.
  task automatic pause();
    int roll, gap;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 4);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the request until the block takes it, then note it for prediction.
  task automatic issue(input logic m, input logic [CELL_W-1:0] r, input logic [CELL_W-1:0] c,
                       input logic [BELIEF_W-1:0] bel, input logic [COUNT_W-1:0] cnt,
                       input logic [BUDGET_W-1:0] bud);
    start <= 1'b1;
    mode <= m;
    cell_row <= r;
    cell_col <= c;
    belief <= bel;
    visit_count <= cnt;
    budget <= bud;
    do @(posedge clk); while (busy !== 1'b0);
    sb.accept_request(m, r, c, bel, cnt, bud);
    if (m) begin
      n_plans++;
    end else begin
      n_loads++;
      cell_loaded[int'(r) * DEF_MAX_COLS + int'(c)] = 1'b1;
    end
    pause();
  endtask

  // Budget rides along with random bits; the block ignores it on loads.
  task automatic load_cell(input int r, input int c, input logic [BELIEF_W-1:0] bel,
                           input logic [COUNT_W-1:0] cnt);
    issue(1'b0, CELL_W'(r), CELL_W'(c), bel, cnt, BUDGET_W'($urandom));
  endtask

  // Cell fields carry junk on plans; only the budget matters.
  task automatic request_plan(input logic [BUDGET_W-1:0] bud);
    issue(1'b1, CELL_W'($urandom), CELL_W'($urandom), BELIEF_W'($urandom),
          COUNT_W'($urandom), bud);
  endtask

  // Wait out every owed visit and any load still in flight.
  task automatic settle();
    start <= 1'b0;
    while (sb.planned_visits.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
    n_writes++;
  endtask

  // Reprogram all registers while idle; grid writes carry junk in the upper bits.
  task automatic configure(input logic [PROB_W-1:0] p, input int rows, input int cols,
                           input bit spare);
    settle();
    write_reg(CFG_DETECT_PROB, p);
    write_reg(CFG_GRID_ROWS, {12'($urandom), DIM_W'(rows)});
    write_reg(CFG_GRID_COLS, {12'($urandom), DIM_W'(cols)});
    if (spare) write_reg(CFG_SPARE, PROB_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Never let a plan scan a cell whose gain was never written.
  task automatic fill_grid();
    for (int r = 0; r < sb.active_rows(); r++) begin
      for (int c = 0; c < sb.active_cols(); c++) begin
        if (!cell_loaded[r * DEF_MAX_COLS + c])
          load_cell(r, c, BELIEF_W'($urandom), COUNT_W'($urandom_range(0, 3)));
      end
    end
  endtask

  // Mostly loads inside the active grid followed by plans of modest budget;
  // repeated beliefs make ties so the first-maximum rule gets exercised.
  task automatic random_phase(input int n_items);
    int                  roll, rows, cols, r, c;
    logic [BELIEF_W-1:0] bel, tie_bel;
    logic [COUNT_W-1:0]  cnt, tie_cnt;
    logic [BUDGET_W-1:0] bud;
    tie_bel = BELIEF_W'($urandom);
    tie_cnt = '0;
    fill_grid();
    for (int i = 0; i < n_items; i++) begin
      rows = sb.active_rows();
      cols = sb.active_cols();
      roll = $urandom_range(0, 99);
      if (roll < 58) begin
        if ($urandom_range(0, 4) != 0) begin
          r = $urandom_range(0, rows - 1);
          c = $urandom_range(0, cols - 1);
        end else begin
          r = $urandom_range(0, 15);
          c = $urandom_range(0, 15);
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) cnt = COUNT_W'($urandom_range(0, 3));
        else if (roll < 90) cnt = COUNT_W'($urandom_range(4, 24));
        else cnt = COUNT_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          bel = '0;
        end else if (roll < 20) begin
          bel = '1;
        end else if (roll < 35) begin
          bel = tie_bel;
          cnt = tie_cnt;
        end else begin
          bel = BELIEF_W'($urandom);
        end
        load_cell(r, c, bel, cnt);
        tie_bel = bel;
        tie_cnt = cnt;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8) bud = '0;
        else if (roll < 70) bud = BUDGET_W'($urandom_range(1, 8));
        else if (roll < 85) bud = BUDGET_W'($urandom_range(9, 24));
        else bud = BUDGET_W'($urandom_range(64, 127));
        // big grids scan slowly; keep their plans short
        if (rows * cols > 64 && bud > 12) bud = BUDGET_W'($urandom_range(1, 12));
        request_plan(bud);
      end
    end
  endtask

  initial begin
    sb = new();
    n_loads = 0;
    n_plans = 0;
    n_writes = 0;
    steady = 1'b0;
    foreach (cell_loaded[i]) cell_loaded[i] = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= 1'b0;
    cell_row <= '0;
    cell_col <= '0;
    belief <= '0;
    visit_count <= '0;
    budget <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DETECT_PROB;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: half probability on a 2x3 grid, plus the unmapped index.
    configure(DETECT_PROB_RST, 2, 3, 1'b1);
    load_cell(0, 0, 16'hFFFF, 8'd0);    // largest belief
    load_cell(0, 1, 16'h0000, 8'd0);    // zero gain, never chosen
    load_cell(0, 2, 16'hFFFF, 8'd0);    // ties with the first cell, must lose
    load_cell(1, 0, 16'h0001, 8'hFF);   // decays to nothing over many visits
    load_cell(1, 1, 16'd40000, 8'd1);
    load_cell(1, 2, 16'd20000, 8'd0);
    load_cell(15, 15, 16'hFFFF, 8'hFF); // corner cell outside the grid in use
    request_plan(7'd0);                 // zero budget: single empty result
    request_plan(7'h7F);                // budget saturates at the maximum
    request_plan(7'd1);
    request_plan(7'd5);

    // Zero probability on a grid of zero size (acts as 1x1): the chosen gain
    // never decays, then a reload with zero gain leaves nothing positive.
    configure('0, 0, 0, 1'b0);
    request_plan(7'd3);
    load_cell(0, 0, 16'hFFFF, 8'd7);
    request_plan(7'd4);

    // Probability above one saturates: each positive cell is visited once and
    // the plan ends early.
    configure('1, 2, 3, 1'b0);
    request_plan(7'd64);

    // Random phases; the first runs back to back with no gaps. Oversized
    // row and column counts saturate to the full grid edge.
    steady = 1'b1;
    configure(PROB_W'($urandom_range(1, 65535)), $urandom_range(1, 4),
              $urandom_range(1, 4), 1'b0);
    random_phase(12);
    steady = 1'b0;
    configure(ONE_Q16, 3, 5, 1'b0);
    random_phase(12);
    configure(PROB_W'($urandom_range(1, 65535)), 16, 1, 1'b0);
    random_phase(12);
    configure(PROB_W'($urandom_range(1, 65535)), 1, 31, 1'b0);
    random_phase(12);
    configure(PROB_W'($urandom_range(1, 65535)), 31, 2, 1'b0);
    random_phase(12);
    configure(PROB_W'($urandom_range(0, 131071)), $urandom_range(0, 31),
              $urandom_range(0, 2), 1'b1);
    random_phase(10);

    settle();
    $display("Covered %0d cell loads and %0d plans over %0d register writes,",
             n_loads, n_plans, n_writes);
    $display("grids from 1x1 up to 16x2 and 1x16; %0d visits checked, %0d mismatches.",
             sb.visits_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.planned_visits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: greedy_search_visit_planner.f
rtl/gsvp_pkg.sv
rtl/gsvp_sequencer.sv
rtl/gsvp_datapath.sv
rtl/greedy_search_visit_planner.sv
verif/tb_greedy_search_visit_planner.sv
